/* rtl/core/pic_pkg.sv */
package pic_pkg;

   localparam int NUM_SOURCES_DEF   = 128;
   localparam int NUM_HARTS_DEF     = 4;
   localparam int PRIORITY_BITS_DEF = 3;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_RAISE = 2'd2;

   localparam logic [21:0] PENDING_BASE  = 22'h001000;
   localparam logic [21:0] ENABLE_BASE   = 22'h002000;
   localparam logic [21:0] CTX_BASE      = 22'h200000;
   localparam int          ENABLE_STRIDE = 'h80;
   localparam int          CTX_STRIDE    = 'h1000;
   localparam int          MAX_LINES     = 8;

endpackage

/* rtl/core/pic_ram.sv */
module pic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/platform_interrupt_controller_unit.sv */
// Platform-level interrupt controller with the standard PLIC register map
// (priority at 4*source, pending words at 0x1000, enables at 0x2000+ctx*0x80,
// threshold at 0x200000+ctx*0x1000, claim/complete at threshold+4). Per-source
// state (priority, pending, in-service) lives in one synchronous RAM, one
// entry per source; enable words live in a second RAM. One item is taken at a
// time. After reset a clearing pass over max(NUM_SOURCES, 2*NUM_HARTS*NWORDS)
// entries zeroes the stores; no item is accepted during it. Each item then
// passes the access states ST_ACC and ST_ACC2, a full rescan of all sources
// for every context to refresh the interrupt lines, and ST_DONE to load the
// result; the rescan reads the sources in turn through the one read port of
// the source RAM. A claim read first scans its own context, retires the
// claim and then rescans every context. A pending-word read first gathers
// the pending bits of its word. The result sits in an output register, so
// the next item is accepted while it waits; a result that is still not taken
// holds the following item in ST_DONE.
module platform_interrupt_controller_unit #(
   parameter int NUM_SOURCES   = pic_pkg::NUM_SOURCES_DEF,
   parameter int NUM_HARTS     = pic_pkg::NUM_HARTS_DEF,
   parameter int PRIORITY_BITS = pic_pkg::PRIORITY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [21:0] req_offset,
   input  logic [31:0] req_write_data,
   input  logic [6:0]  req_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [7:0]  rsp_irq_lines,
   output logic        rsp_access_error
);

   localparam int NCTX     = 2 * NUM_HARTS;
   localparam int NWORDS   = (NUM_SOURCES + 31) / 32;
   localparam int SW       = $clog2(NUM_SOURCES);
   localparam int CXW      = $clog2(NCTX);
   localparam int EDEPTH   = NCTX * NWORDS;
   localparam int EAW      = $clog2(EDEPTH);
   localparam int CLR_LAST = ((NUM_SOURCES > EDEPTH) ? NUM_SOURCES : EDEPTH) - 1;
   localparam int PB       = PRIORITY_BITS;
   localparam int SEW      = PB + 2;
   localparam int NL       = (NCTX < pic_pkg::MAX_LINES) ? NCTX : pic_pkg::MAX_LINES;
   localparam logic [PB-1:0] PMAX = {PB{1'b1}};

   // state codes
   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_ACC   = 4'd2;
   localparam logic [3:0] ST_ACC2  = 4'd3;
   localparam logic [3:0] ST_PEND  = 4'd4;
   localparam logic [3:0] ST_SCAN  = 4'd5;
   localparam logic [3:0] ST_CLAIM = 4'd6;
   localparam logic [3:0] ST_DONE  = 4'd7;

   // source entry: {in_service, pending, priority}
   logic           s_we;
   logic [SW-1:0]  s_waddr, s_raddr;
   logic [SEW-1:0] s_wdata, s_rdata;
   logic           e_we;
   logic [EAW-1:0] e_waddr, e_raddr;
   logic [31:0]    e_wdata, e_rdata;

   pic_ram #(.WIDTH(SEW), .DEPTH(NUM_SOURCES)) u_src_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata));

   pic_ram #(.WIDTH(32), .DEPTH(EDEPTH)) u_en_ram (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
      .rd_addr(e_raddr), .rd_data(e_rdata));

   logic [3:0]     state_ff, state_in;
   logic [SW:0]    cnt_ff, cnt_in;       // source index during sweeps
   logic [CXW-1:0] ctx_ff, ctx_in;       // context under scan
   logic [1:0]     op_ff;
   logic [21:0]    off_ff;
   logic [31:0]    wd_ff;
   logic [6:0]     src_ff;
   logic [31:0]    rd_ff, rd_in;
   logic           err_ff, err_in;
   logic [7:0]     lines_ff, lines_in;
   logic [SW-1:0]  best_ff, best_in;
   logic [PB-1:0]  bestp_ff, bestp_in;
   logic [SEW-1:0] best_ent_ff, best_ent_in;
   logic           claim_ff, claim_in;    // this item is a claim read
   logic [CXW-1:0] cctx_ff, cctx_in;      // context that claims
   logic           ovalid_ff, ovalid_in;
   logic [31:0]    ord_ff, ord_in;
   logic [7:0]     olines_ff, olines_in;
   logic           oerr_ff, oerr_in;
   logic [PB-1:0]  thr_ff [NCTX];
   logic [PB-1:0]  thr_in [NCTX];

   // address decode of the held item
   logic [21:0] rel_e, rel_c;
   logic [21:0] e_ctx_w, c_ctx_w;
   logic [21:0] e_word_w, c_r;
   logic        aligned;
   logic        in_prio, in_pend, in_en, is_prio_ok, is_pend_ok, is_en_ok;
   logic        is_thr, is_claim, ctx_ok_c;
   logic [21:0] p_src, p_word;
   logic [PB-1:0] sat_wd;
   logic [31:0] wmask;
   logic [EAW-1:0] en_addr_acc;
   logic [SW:0] pend_start, pend_end;

   always_comb begin
      rel_e    = off_ff - pic_pkg::ENABLE_BASE;
      rel_c    = off_ff - pic_pkg::CTX_BASE;
      e_ctx_w  = 22'(rel_e / pic_pkg::ENABLE_STRIDE);
      e_word_w = 22'((rel_e % pic_pkg::ENABLE_STRIDE) >> 2);
      c_ctx_w  = 22'(rel_c / pic_pkg::CTX_STRIDE);
      c_r      = 22'(rel_c % pic_pkg::CTX_STRIDE);
      p_src    = off_ff >> 2;
      p_word   = (off_ff - pic_pkg::PENDING_BASE) >> 2;
      aligned  = (off_ff[1:0] == 2'b00);
      in_prio  = off_ff < pic_pkg::PENDING_BASE;
      in_pend  = !in_prio && off_ff < pic_pkg::ENABLE_BASE;
      in_en    = !in_prio && !in_pend && off_ff < pic_pkg::CTX_BASE;
      is_prio_ok = in_prio && p_src < 22'(NUM_SOURCES);
      is_pend_ok = in_pend && p_word < 22'(NWORDS);
      is_en_ok   = in_en && e_ctx_w < 22'(NCTX) && e_word_w < 22'(NWORDS);
      ctx_ok_c   = !in_prio && !in_pend && !in_en && c_ctx_w < 22'(NCTX);
      is_thr     = ctx_ok_c && c_r == 22'd0;
      is_claim   = ctx_ok_c && c_r == 22'd4;
      sat_wd   = (wd_ff > 32'(PMAX)) ? PMAX : wd_ff[PB-1:0];
      // enable bits exist for sources 1..NUM_SOURCES-1 only
      for (int b = 0; b < 32; b++) begin
         wmask[b] = (int'(e_word_w) * 32 + b >= 1) &&
                    (int'(e_word_w) * 32 + b < NUM_SOURCES);
      end
      en_addr_acc = EAW'(int'(e_ctx_w) * NWORDS + int'(e_word_w));
      pend_start  = (SW+1)'(int'(p_word) * 32);
      pend_end    = (SW+1)'(int'(p_word) * 32 + 32);
   end

   // scan enable bit selection
   logic [EAW-1:0] scan_eaddr;
   logic [SW-1:0]  scan_src;
   logic [SW-1:0]  prev_src;
   logic           scan_en_bit;
   logic           cand;
   always_comb begin
      scan_src    = cnt_ff[SW-1:0];
      prev_src    = scan_src - SW'(1);
      scan_eaddr  = EAW'(int'(ctx_ff) * NWORDS + int'(scan_src >> 5));
      scan_en_bit = e_rdata[prev_src[4:0]];
      cand = s_rdata[PB] && scan_en_bit && (s_rdata[PB-1:0] > bestp_ff) &&
             (prev_src != '0);
   end

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; ctx_in = ctx_ff;
      rd_in = rd_ff; err_in = err_ff; lines_in = lines_ff;
      best_in = best_ff; bestp_in = bestp_ff; best_ent_in = best_ent_ff;
      claim_in = claim_ff; cctx_in = cctx_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      ord_in = ord_ff; olines_in = olines_ff; oerr_in = oerr_ff;
      thr_in = thr_ff;
      s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
      e_we = 1'b0; e_waddr = '0; e_wdata = '0; e_raddr = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            // zero both stores and thresholds
            s_we = (cnt_ff < (SW+1)'(NUM_SOURCES)); s_waddr = cnt_ff[SW-1:0];
            e_we = (cnt_ff < (SW+1)'(EDEPTH)); e_waddr = EAW'(cnt_ff);
            for (int c = 0; c < NCTX; c++) thr_in[c] = '0;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (SW+1)'(CLR_LAST)) begin
               cnt_in = '0; state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_in = '0; err_in = 1'b0; claim_in = 1'b0;
            if (req_valid) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            // source entry read for raise/priority/complete; enable word read
            s_raddr = (op_ff == pic_pkg::OP_RAISE) ? SW'(src_ff) : p_src[SW-1:0];
            state_in = ST_ACC2;
            if (op_ff == pic_pkg::OP_WRITE && is_claim) begin
               s_raddr = SW'(wd_ff);
            end
            e_raddr = en_addr_acc;
         end
         ST_ACC2: begin
            cnt_in = '0; ctx_in = '0; state_in = ST_SCAN;
            best_in = '0; lines_in = '0;
            bestp_in = thr_ff[0];
            if (op_ff == pic_pkg::OP_RAISE) begin
               if (src_ff != 7'd0 && int'(src_ff) < NUM_SOURCES && !s_rdata[PB+1]) begin
                  s_we = 1'b1; s_waddr = SW'(src_ff);
                  s_wdata = {s_rdata[PB+1], 1'b1, s_rdata[PB-1:0]};
               end
            end else if (op_ff == pic_pkg::OP_READ || op_ff == pic_pkg::OP_WRITE) begin
               if (!aligned) begin
                  err_in = 1'b1;
               end else if (in_prio) begin
                  if (!is_prio_ok) err_in = 1'b1;
                  else if (p_src != 22'd0) begin
                     if (op_ff == pic_pkg::OP_WRITE) begin
                        s_we = 1'b1; s_waddr = p_src[SW-1:0];
                        s_wdata = {s_rdata[PB+1:PB], sat_wd};
                     end else begin
                        rd_in = 32'(s_rdata[PB-1:0]);
                     end
                  end
               end else if (in_pend) begin
                  if (!is_pend_ok) err_in = 1'b1;
                  else if (op_ff == pic_pkg::OP_READ) begin
                     state_in = ST_PEND;
                     cnt_in = pend_start;
                     rd_in = '0;
                  end
               end else if (in_en) begin
                  if (!is_en_ok) err_in = 1'b1;
                  else if (op_ff == pic_pkg::OP_WRITE) begin
                     e_we = 1'b1; e_waddr = en_addr_acc; e_wdata = wd_ff & wmask;
                  end else begin
                     rd_in = e_rdata;
                  end
               end else if (!ctx_ok_c) begin
                  err_in = 1'b1;
               end else if (is_thr) begin
                  if (op_ff == pic_pkg::OP_WRITE) begin
                     thr_in[c_ctx_w[CXW-1:0]] = sat_wd;
                     if (c_ctx_w == 22'd0) bestp_in = sat_wd;
                  end else begin
                     rd_in = 32'(thr_ff[c_ctx_w[CXW-1:0]]);
                  end
               end else if (is_claim) begin
                  if (op_ff == pic_pkg::OP_WRITE) begin
                     if (wd_ff >= 32'd1 && wd_ff < 32'(NUM_SOURCES)) begin
                        s_we = 1'b1; s_waddr = SW'(wd_ff);
                        s_wdata = {1'b0, s_rdata[PB:0]};
                     end
                  end else begin
                     // scan the claiming context first
                     claim_in = 1'b1; cctx_in = c_ctx_w[CXW-1:0];
                     ctx_in = c_ctx_w[CXW-1:0];
                     bestp_in = thr_ff[c_ctx_w[CXW-1:0]];
                  end
               end else begin
                  err_in = 1'b1;
               end
            end
         end
         ST_PEND: begin
            // one source per cycle into the pending word; cnt leads by one
            s_raddr = scan_src;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != pend_start && prev_src != '0) begin
               rd_in[prev_src[4:0]] = s_rdata[PB];
            end
            if (cnt_ff == pend_end || cnt_ff == (SW+1)'(NUM_SOURCES)) begin
               state_in = ST_SCAN; cnt_in = '0; ctx_in = '0;
               best_in = '0; bestp_in = thr_ff[0];
            end
         end
         ST_SCAN: begin
            // read source cnt, evaluate source cnt-1
            s_raddr = scan_src; e_raddr = scan_eaddr;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0 && cand) begin
               best_in = prev_src; bestp_in = s_rdata[PB-1:0]; best_ent_in = s_rdata;
            end
            if (cnt_ff == (SW+1)'(NUM_SOURCES)) begin
               cnt_in = '0;
               if (claim_ff && ctx_ff == cctx_ff) begin
                  state_in = ST_CLAIM;
               end else begin
                  if (best_in != '0 && int'(ctx_ff) < NL) lines_in[3'(ctx_ff)] = 1'b1;
                  best_in = '0;
                  if (ctx_ff == CXW'(NCTX - 1)) begin
                     state_in = ST_DONE;
                  end else begin
                     ctx_in = ctx_ff + 1'b1;
                     bestp_in = thr_ff[ctx_ff + 1'b1];
                  end
               end
            end
         end
         ST_CLAIM: begin
            // retire the claim, then rescan every context
            rd_in = 32'(best_ff); claim_in = 1'b0;
            if (best_ff != '0) begin
               s_we = 1'b1; s_waddr = best_ff;
               s_wdata = {1'b1, 1'b0, best_ent_ff[PB-1:0]};
            end
            best_in = '0; ctx_in = '0; bestp_in = thr_ff[0]; cnt_in = '0;
            state_in = ST_SCAN;
         end
         ST_DONE: begin
            if (!ovalid_ff || rsp_ready) begin
               ovalid_in = 1'b1; ord_in = rd_ff; olines_in = lines_ff; oerr_in = err_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; cnt_ff <= '0; ctx_ff <= '0; ovalid_ff <= 1'b0;
         claim_ff <= 1'b0; err_ff <= 1'b0; lines_ff <= '0;
         for (int c = 0; c < NCTX; c++) thr_ff[c] <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; ctx_ff <= ctx_in;
         ovalid_ff <= ovalid_in; claim_ff <= claim_in; err_ff <= err_in;
         lines_ff <= lines_in; thr_ff <= thr_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in; best_ff <= best_in; bestp_ff <= bestp_in;
      best_ent_ff <= best_ent_in; cctx_ff <= cctx_in;
      ord_ff <= ord_in; olines_ff <= olines_in; oerr_ff <= oerr_in;
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff <= req_operation; off_ff <= req_offset;
         wd_ff <= req_write_data; src_ff <= req_source;
      end
   end

   assign rsp_valid        = ovalid_ff;
   assign rsp_read_data    = ord_ff;
   assign rsp_irq_lines    = olines_ff;
   assign rsp_access_error = oerr_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_ready) else $error("item taken during clear");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("result dropped");
   a_claim_ctx: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLAIM |-> ctx_ff == cctx_ff) else $error("claim on wrong context");
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_access_error |-> rsp_read_data == '0)
      else $error("error with data");
`endif

endmodule
